### rtl/tsr_pkg.sv
// Shared widths, types and codes for the two-axis servo ramp.
// No dependencies; compile first.
package tsr_pkg;

    localparam int ANGLE_W    = 8;
    localparam int HALF_W     = 7;
    localparam int STEP_W     = 4;
    localparam int OFFSET_W   = 9;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // mechanical travel limits, degrees
    localparam int MIN_ANGLE = 0;
    localparam int MAX_ANGLE = 180;

    typedef logic [ANGLE_W-1:0]           t_angle;
    typedef logic [HALF_W-1:0]            t_half;
    typedef logic [STEP_W-1:0]            t_step;
    typedef logic signed [OFFSET_W-1:0]   t_offset;
    typedef logic [FUNC_W-1:0]            t_func;
    typedef logic [CFG_IDX_W-1:0]         t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]        t_cfg_data;

    localparam t_func FUNC_TICK   = 2'd0;
    localparam t_func FUNC_MOVE   = 2'd1;
    localparam t_func FUNC_CENTER = 2'd2;

    localparam t_cfg_idx REG_X_CENTER     = 3'd0;
    localparam t_cfg_idx REG_Y_CENTER     = 3'd1;
    localparam t_cfg_idx REG_X_HALF_RANGE = 3'd2;
    localparam t_cfg_idx REG_Y_HALF_RANGE = 3'd3;
    localparam t_cfg_idx REG_STEP_SIZE    = 3'd4;
    localparam t_cfg_idx REG_HEAD_ENABLE  = 3'd5;

    localparam t_angle RST_CENTER = 8'd90;
    localparam t_half  RST_HALF   = 7'd30;
    localparam t_step  RST_STEP   = 4'd1;
    localparam t_angle RST_ANGLE  = 8'd90;

    typedef struct packed {
        t_angle x_angle;
        t_angle y_angle;
        logic   moving;
    } t_res;

endpackage

### rtl/tsr_if.sv
// Channel interfaces for the two-axis servo ramp: command, result, config write.
// Depends on tsr_pkg.
interface tsr_cmd_if;
    logic               valid;
    logic               ready;
    tsr_pkg::t_func     func;
    tsr_pkg::t_offset   x_delta;
    tsr_pkg::t_offset   y_delta;
    modport source (output valid, func, x_delta, y_delta, input ready);
    modport sink   (input valid, func, x_delta, y_delta, output ready);
endinterface

interface tsr_res_if;
    logic               valid;
    logic               ready;
    tsr_pkg::t_angle    x_angle;
    tsr_pkg::t_angle    y_angle;
    logic               moving;
    modport source (output valid, x_angle, y_angle, moving, input ready);
    modport sink   (input valid, x_angle, y_angle, moving, output ready);
endinterface

interface tsr_cfg_if;
    logic               valid;
    logic               ready;
    tsr_pkg::t_cfg_idx  index;
    tsr_pkg::t_cfg_data data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/two_axis_servo_ramp.sv
// Two-axis servo slew limiter: top level.
// Depends on tsr_pkg and the channel interfaces in tsr_if.sv.
//
// Usage:
//   i_cmd  - command channel: func (tick, relative move, return to center)
//            plus signed x/y offsets. Each transaction gives exactly one
//            result transaction on o_res: both current angles and a moving
//            flag.
//   i_cfg  - register write channel (index, data); always ready. Write only
//            while no command is in flight.
//   Path: an accepted command lands in the input register, is evaluated
//   against the axis state by the combinational update (window clamp,
//   target clamp, step) and its result is registered into the output
//   register, or into the skid entry while the output is held.
//   Throughput: one command per cycle while the skid entry is empty.
//   Stall: the output register is backed by a one-entry skid register, so a
//   stalled receiver still lets one more command complete; i_cmd.ready drops
//   only when the input register and the skid entry are both full.
//   Reset (synchronous, active low): angles and targets go to 90 degrees,
//   registers to their defaults, all channels empty.
module two_axis_servo_ramp (
    input  logic    i_clk,
    input  logic    i_rst_n,
    tsr_cmd_if.sink i_cmd,
    tsr_cfg_if.sink i_cfg,
    tsr_res_if.source o_res
);
    import tsr_pkg::*;

    localparam int WIDE_W = 11;
    typedef logic signed [WIDE_W-1:0] t_wide;

    typedef struct packed {
        t_wide ec;
        t_wide lo;
        t_wide hi;
    } t_win;

    function automatic t_wide clamp_w(t_wide v, t_wide lo, t_wide hi);
        t_wide r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // lower bound tested first, so crossed bounds still give a value
    function automatic t_win axis_window(t_angle center, t_half half);
        t_win  w;
        t_wide h;
        t_wide l;
        t_wide u;
        h    = t_wide'(half);
        w.ec = clamp_w(t_wide'(center), t_wide'(MIN_ANGLE) + h, t_wide'(MAX_ANGLE) - h);
        l    = w.ec - h;
        u    = w.ec + h;
        w.lo = (l < t_wide'(MIN_ANGLE)) ? t_wide'(MIN_ANGLE) : l;
        w.hi = (u > t_wide'(MAX_ANGLE)) ? t_wide'(MAX_ANGLE) : u;
        return w;
    endfunction

    function automatic t_angle step_toward(t_angle cur, t_angle tgt, t_angle step);
        t_angle r;
        if (tgt > cur) begin
            r = ((tgt - cur) > step) ? cur + step : tgt;
        end else if (tgt < cur) begin
            r = ((cur - tgt) > step) ? cur - step : tgt;
        end else begin
            r = cur;
        end
        return r;
    endfunction

    // configuration
    t_angle r_x_center, r_y_center;
    t_half  r_x_half, r_y_half;
    t_step  r_step;
    logic   r_enable;

    // axis state
    t_angle r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    t_angle n_cur_x, n_cur_y, n_tgt_x, n_tgt_y;

    // input register
    logic    r_in_valid;
    t_func   r_in_func;
    t_offset r_in_x_off, r_in_y_off;

    // output register and skid entry
    logic r_out_valid, r_skid_valid;
    t_res r_out, r_skid;
    t_res n_res;

    logic cmd_take, push, out_pop;
    t_win win_x, win_y;
    t_angle step_eff;

    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = !r_in_valid || !r_skid_valid;
    assign cmd_take    = i_cmd.valid && i_cmd.ready;
    assign push        = r_in_valid && !r_skid_valid;
    assign out_pop     = r_out_valid && o_res.ready;

    assign o_res.valid   = r_out_valid;
    assign o_res.x_angle = r_out.x_angle;
    assign o_res.y_angle = r_out.y_angle;
    assign o_res.moving  = r_out.moving;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_center <= RST_CENTER;
            r_y_center <= RST_CENTER;
            r_x_half   <= RST_HALF;
            r_y_half   <= RST_HALF;
            r_step     <= RST_STEP;
            r_enable   <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_X_CENTER:     r_x_center <= i_cfg.data;
                REG_Y_CENTER:     r_y_center <= i_cfg.data;
                REG_X_HALF_RANGE: r_x_half   <= i_cfg.data[HALF_W-1:0];
                REG_Y_HALF_RANGE: r_y_half   <= i_cfg.data[HALF_W-1:0];
                REG_STEP_SIZE:    r_step     <= i_cfg.data[STEP_W-1:0];
                REG_HEAD_ENABLE:  r_enable   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        win_x    = axis_window(r_x_center, r_x_half);
        win_y    = axis_window(r_y_center, r_y_half);
        step_eff = (r_step == '0) ? t_angle'(1) : t_angle'(r_step);
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_tgt_x  = r_tgt_x;
        n_tgt_y  = r_tgt_y;
        case (r_in_func)
            FUNC_TICK: begin
                n_cur_x = step_toward(r_cur_x, r_tgt_x, step_eff);
                n_cur_y = step_toward(r_cur_y, r_tgt_y, step_eff);
            end
            FUNC_MOVE: begin
                if (r_enable) begin
                    n_tgt_x = t_angle'(clamp_w(t_wide'(r_cur_x) + t_wide'(r_in_x_off),
                                               win_x.lo, win_x.hi));
                    n_tgt_y = t_angle'(clamp_w(t_wide'(r_cur_y) + t_wide'(r_in_y_off),
                                               win_y.lo, win_y.hi));
                end
            end
            FUNC_CENTER: begin
                if (r_enable) begin
                    n_tgt_x = t_angle'(clamp_w(win_x.ec, win_x.lo, win_x.hi));
                    n_tgt_y = t_angle'(clamp_w(win_y.ec, win_y.lo, win_y.hi));
                end
            end
            default: ;
        endcase
        n_res.x_angle = n_cur_x;
        n_res.y_angle = n_cur_y;
        n_res.moving  = (n_cur_x != n_tgt_x) || (n_cur_y != n_tgt_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
            r_cur_x      <= RST_ANGLE;
            r_cur_y      <= RST_ANGLE;
            r_tgt_x      <= RST_ANGLE;
            r_tgt_y      <= RST_ANGLE;
        end else begin
            if (cmd_take) begin
                r_in_valid <= 1'b1;
                r_in_func  <= i_cmd.func;
                r_in_x_off <= i_cmd.x_delta;
                r_in_y_off <= i_cmd.y_delta;
            end else if (push) begin
                r_in_valid <= 1'b0;
            end

            if (push) begin
                r_cur_x <= n_cur_x;
                r_cur_y <= n_cur_y;
                r_tgt_x <= n_tgt_x;
                r_tgt_y <= n_tgt_y;
            end

            // output slot free: drain skid first to keep order
            if (!r_out_valid || out_pop) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else if (push) begin
                    r_out       <= n_res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (push) begin
                r_skid       <= n_res;
                r_skid_valid <= 1'b1;
            end
        end
    end

endmodule

### verif/servo_ramp_checker.sv
`timescale 1ns / 100ps
// Result checker for the two-axis servo ramp: watches command, config and result channels.
// Depends on tsr_pkg and the channel interfaces in tsr_if.sv.
module servo_ramp_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    tsr_cmd_if   i_cmd,
    tsr_cfg_if   i_cfg,
    tsr_res_if   i_res,
    output int   o_err_cnt,
    output int   o_pending
);
    import tsr_pkg::*;

    localparam int MAX_REPORTS = 10;

    // shadow registers and axis state
    t_angle x_center_q, y_center_q;
    t_half  x_half_q, y_half_q;
    t_step  step_q;
    logic   enable_q;
    t_angle pos_x, pos_y, goal_x, goal_y;

    t_res angle_q[$];
    int   mismatches;

    function automatic int clamp_deg(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // crossed bounds: the lower bound wins only below it, else the upper bound
    function automatic void travel_window(input int center, input int half,
                                          output int eff, output int lo, output int hi);
        eff = clamp_deg(center, MIN_ANGLE + half, MAX_ANGLE - half);
        lo  = (eff - half < MIN_ANGLE) ? MIN_ANGLE : eff - half;
        hi  = (eff + half > MAX_ANGLE) ? MAX_ANGLE : eff + half;
    endfunction

    function automatic t_angle slew(t_angle cur, t_angle tgt, int stp);
        int c, t;
        c = int'(cur);
        t = int'(tgt);
        if (t > c) return t_angle'((t - c > stp) ? c + stp : t);
        if (t < c) return t_angle'((c - t > stp) ? c - stp : t);
        return cur;
    endfunction

    function automatic t_res apply_command(t_func f, t_offset dx, t_offset dy);
        int   ecx, lox, hix, ecy, loy, hiy, stp;
        t_res r;
        travel_window(int'(x_center_q), int'(x_half_q), ecx, lox, hix);
        travel_window(int'(y_center_q), int'(y_half_q), ecy, loy, hiy);
        case (f)
            FUNC_TICK: begin
                stp   = (step_q == '0) ? 1 : int'(step_q);
                pos_x = slew(pos_x, goal_x, stp);
                pos_y = slew(pos_y, goal_y, stp);
            end
            FUNC_MOVE: begin
                if (enable_q) begin
                    goal_x = t_angle'(clamp_deg(int'(pos_x) + int'(dx), lox, hix));
                    goal_y = t_angle'(clamp_deg(int'(pos_y) + int'(dy), loy, hiy));
                end
            end
            FUNC_CENTER: begin
                if (enable_q) begin
                    goal_x = t_angle'(clamp_deg(ecx, lox, hix));
                    goal_y = t_angle'(clamp_deg(ecy, loy, hiy));
                end
            end
            default: ;
        endcase
        r.x_angle = pos_x;
        r.y_angle = pos_y;
        r.moving  = (pos_x != goal_x) || (pos_y != goal_y);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res got, want;
        if (!i_rst_n) begin
            x_center_q = RST_CENTER;
            y_center_q = RST_CENTER;
            x_half_q   = RST_HALF;
            y_half_q   = RST_HALF;
            step_q     = RST_STEP;
            enable_q   = 1'b1;
            pos_x      = RST_ANGLE;
            pos_y      = RST_ANGLE;
            goal_x     = RST_ANGLE;
            goal_y     = RST_ANGLE;
            angle_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.x_angle = i_res.x_angle;
                got.y_angle = i_res.y_angle;
                got.moving  = i_res.moving;
                if (angle_q.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: unexpected result x=%0d y=%0d moving=%0b",
                                 $time, got.x_angle, got.y_angle, got.moving);
                    mismatches++;
                end else begin
                    want = angle_q.pop_front();
                    if (got.x_angle !== want.x_angle || got.y_angle !== want.y_angle ||
                        got.moving !== want.moving) begin
                        if (mismatches < MAX_REPORTS)
                            $display({"%0t: mismatch: expected x=%0d y=%0d moving=%0b,",
                                      " got x=%0d y=%0d moving=%0b"},
                                     $time, want.x_angle, want.y_angle, want.moving,
                                     got.x_angle, got.y_angle, got.moving);
                        mismatches++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_X_CENTER:     x_center_q = i_cfg.data;
                    REG_Y_CENTER:     y_center_q = i_cfg.data;
                    REG_X_HALF_RANGE: x_half_q   = i_cfg.data[HALF_W-1:0];
                    REG_Y_HALF_RANGE: y_half_q   = i_cfg.data[HALF_W-1:0];
                    REG_STEP_SIZE:    step_q     = i_cfg.data[STEP_W-1:0];
                    REG_HEAD_ENABLE:  enable_q   = i_cfg.data[0];
                    default: ;
                endcase
            end
            if (i_cmd.valid && i_cmd.ready)
                angle_q.push_back(apply_command(i_cmd.func, i_cmd.x_delta, i_cmd.y_delta));
        end
        o_err_cnt = mismatches;
        o_pending = angle_q.size();
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// Top of the servo ramp testbench: clock, reset, command and register stimulus, result
// back-pressure and verdict. Depends on tsr_pkg, tsr_if.sv, the block and servo_ramp_checker.
module testbench;
    import tsr_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SEGMENTS        = 4;
    localparam int SEG_ITEMS       = 156;

    localparam t_func   FUNC_UNUSED = 2'd3;
    localparam t_offset OFS_MAX     = 9'sh0FF;
    localparam t_offset OFS_MIN     = 9'sh100;
    localparam t_offset OFS_ZERO    = 9'sh000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   send_idle_pct, recv_idle_pct;
    bit   hold_off_req;
    int   err_cnt, pending;
    int   quiet_cycles;

    tsr_cmd_if cmd_ch();
    tsr_cfg_if cfg_ch();
    tsr_res_if res_ch();

    two_axis_servo_ramp dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    servo_ramp_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd_ch),
        .i_cfg     (cfg_ch),
        .i_res     (res_ch),
        .o_err_cnt (err_cnt),
        .o_pending (pending)
    );

    always #4 i_clk = ~i_clk;

    // result side back-pressure; a long hold-off fills the block and stalls i_cmd
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_cmd(t_func f, t_offset dx, t_offset dy);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.func    <= f;
        cmd_ch.x_delta <= dx;
        cmd_ch.y_delta <= dy;
        do @(posedge i_clk); while (!cmd_ch.ready);
    endtask

    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_cfg_data val);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_config(int xc, int yc, int xh, int yh, int stp, int en);
        write_reg(REG_X_CENTER, t_cfg_data'(xc));
        write_reg(REG_Y_CENTER, t_cfg_data'(yc));
        write_reg(REG_X_HALF_RANGE, t_cfg_data'(xh));
        write_reg(REG_Y_HALF_RANGE, t_cfg_data'(yh));
        write_reg(REG_STEP_SIZE, t_cfg_data'(stp));
        write_reg(REG_HEAD_ENABLE, t_cfg_data'(en));
    endtask

    // mostly legal ranges, sometimes anything the register width allows
    task automatic random_config();
        int xc, yc, xh, yh;
        xc = ($urandom_range(99) < 85) ? $urandom_range(180) : $urandom_range(255);
        yc = ($urandom_range(99) < 85) ? $urandom_range(180) : $urandom_range(255);
        xh = ($urandom_range(99) < 85) ? $urandom_range(90) : $urandom_range(127);
        yh = ($urandom_range(99) < 85) ? $urandom_range(90) : $urandom_range(127);
        set_config(xc, yc, xh, yh, $urandom_range(15), ($urandom_range(9) != 0));
    endtask

    function automatic t_offset rand_offset();
        if ($urandom_range(3) == 0) return t_offset'($urandom);
        return t_offset'(int'($urandom_range(120)) - 60);
    endfunction

    task automatic random_item();
        int    pick;
        t_func f;
        pick = $urandom_range(99);
        if (pick < 55)      f = FUNC_TICK;
        else if (pick < 85) f = FUNC_MOVE;
        else if (pick < 95) f = FUNC_CENTER;
        else                f = FUNC_UNUSED;
        send_cmd(f, rand_offset(), rand_offset());
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.func    <= FUNC_TICK;
        cmd_ch.x_delta <= OFS_ZERO;
        cmd_ch.y_delta <= OFS_ZERO;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= REG_X_CENTER;
        cfg_ch.data    <= '0;
        send_idle_pct = 12;
        recv_idle_pct = 51;
        hold_off_req  = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: at rest, widest offsets, center, unused func
        send_cmd(FUNC_TICK, OFS_ZERO, OFS_ZERO);
        send_cmd(FUNC_MOVE, OFS_MAX, OFS_MIN);
        send_cmd(FUNC_TICK, OFS_ZERO, OFS_ZERO);
        send_cmd(FUNC_CENTER, OFS_MIN, OFS_MAX);
        send_cmd(FUNC_TICK, OFS_ZERO, OFS_ZERO);
        send_cmd(FUNC_UNUSED, OFS_MAX, OFS_MAX);
        send_cmd(FUNC_MOVE, OFS_ZERO, OFS_ZERO);

        // zero step, center at the ends, oversized half range on y
        set_config(0, 255, 90, 127, 0, 1);
        send_cmd(FUNC_MOVE, OFS_MIN, OFS_MAX);
        send_cmd(FUNC_TICK, OFS_ZERO, OFS_ZERO);
        write_reg(REG_STEP_SIZE, t_cfg_data'(15));
        send_cmd(FUNC_TICK, OFS_ZERO, OFS_ZERO);
        send_cmd(FUNC_TICK, OFS_ZERO, OFS_ZERO);
        send_cmd(FUNC_TICK, OFS_ZERO, OFS_ZERO);
        send_cmd(FUNC_CENTER, OFS_ZERO, OFS_ZERO);
        send_cmd(FUNC_TICK, OFS_ZERO, OFS_ZERO);

        // disabled: commands ignored, ticks still move
        write_reg(REG_HEAD_ENABLE, t_cfg_data'(0));
        send_cmd(FUNC_MOVE, OFS_MAX, OFS_MIN);
        send_cmd(FUNC_CENTER, OFS_ZERO, OFS_ZERO);
        send_cmd(FUNC_TICK, OFS_ZERO, OFS_ZERO);

        // zero half range pins both axes to the window
        set_config(180, 0, 0, 0, 15, 1);
        send_cmd(FUNC_CENTER, OFS_ZERO, OFS_ZERO);
        send_cmd(FUNC_TICK, OFS_ZERO, OFS_ZERO);
        send_cmd(FUNC_TICK, OFS_ZERO, OFS_ZERO);
        send_cmd(FUNC_MOVE, t_offset'(5), t_offset'(-5));
        send_cmd(FUNC_TICK, OFS_ZERO, OFS_ZERO);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 51 : 0;
            recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 12 : 0;
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                random_config();
                for (int n = 0; n < SEG_ITEMS; n++) begin
                    if (phase == 0 && seg == 1 && n == 40)
                        hold_off_req = 1'b1;
                    random_item();
                end
            end
        end

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (err_cnt == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/tsr_pkg.sv
rtl/tsr_if.sv
rtl/two_axis_servo_ramp.sv
verif/servo_ramp_checker.sv
verif/testbench.sv
